FILE: rtl/dsdf_pkg.sv
// ----------------------------------------------------------------------------
// dsdf_pkg
// Shared widths, codes and types of the stereo delay-and-sum direction finder.
// ----------------------------------------------------------------------------
`default_nettype none

package dsdf_pkg;

  localparam int SampleW   = 16;
  localparam int CoefW     = 17;
  localparam int CoefRegs  = 8;
  localparam int CfgIdxW   = 3;
  localparam int ProdW     = SampleW + CoefW;   // one tap product
  localparam int PsumW     = ProdW + 3;         // room for up to eight taps
  localparam int FracBits  = 16;
  localparam int FiltW     = PsumW - FracBits;  // filtered sample after >>16
  localparam int SumW      = FiltW + 1;         // left + right
  localparam int SqW       = 2 * SumW;
  localparam int PowerW    = 45;
  localparam int VoteW     = 8;
  localparam int DirW      = 2;

  localparam logic [PowerW-1:0] PowerMax = {PowerW{1'b1}};
  localparam logic [VoteW-1:0]  VoteMax  = {VoteW{1'b1}};

  localparam logic [DirW-1:0] DirCenter = 2'd0;
  localparam logic [DirW-1:0] DirRight  = 2'd1;
  localparam logic [DirW-1:0] DirLeft   = 2'd2;

  localparam int TapCountDef       = 8;
  localparam int WindowSamplesDef  = 64;
  localparam int SteerLagDef       = 3;
  localparam int WinPerDecisionDef = 30;

  // Control of one steering's energy path
  typedef struct packed {
    logic sum_en;   // take the steered sum
    logic sq_en;    // register its square
    logic acc_en;   // add the square into the window energy
    logic clr;      // window done, start over
  } acc_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/dsdf_tap_cell.sv
// ----------------------------------------------------------------------------
// dsdf_tap_cell
// One FIR tap for both channels: holds a history sample, passes it on when a
// request is taken, and adds its product into the partial sum from its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module dsdf_tap_cell (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      shift_i,
  input  wire  signed [dsdf_pkg::CoefW-1:0]        coef_i,
  input  wire  signed [dsdf_pkg::SampleW-1:0]      left_i,
  input  wire  signed [dsdf_pkg::SampleW-1:0]      right_i,
  input  wire  signed [dsdf_pkg::PsumW-1:0]        left_psum_i,
  input  wire  signed [dsdf_pkg::PsumW-1:0]        right_psum_i,
  output logic signed [dsdf_pkg::SampleW-1:0]      left_o,
  output logic signed [dsdf_pkg::SampleW-1:0]      right_o,
  output logic signed [dsdf_pkg::PsumW-1:0]        left_psum_o,
  output logic signed [dsdf_pkg::PsumW-1:0]        right_psum_o
);

  logic signed [dsdf_pkg::SampleW-1:0] left_q, right_q;
  logic signed [dsdf_pkg::ProdW-1:0]   left_prod, right_prod;
  logic signed [dsdf_pkg::PsumW-1:0]   left_psum_q, right_psum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
    end else if (shift_i) begin
      left_q  <= left_i;
      right_q <= right_i;
    end
  end

  assign left_prod  = dsdf_pkg::ProdW'(coef_i) * dsdf_pkg::ProdW'(left_q);
  assign right_prod = dsdf_pkg::ProdW'(coef_i) * dsdf_pkg::ProdW'(right_q);

  // partial sums ripple one cell per cycle
  always_ff @(posedge clk_i) begin
    left_psum_q  <= left_psum_i + dsdf_pkg::PsumW'(left_prod);
    right_psum_q <= right_psum_i + dsdf_pkg::PsumW'(right_prod);
  end

  assign left_o       = left_q;
  assign right_o      = right_q;
  assign left_psum_o  = left_psum_q;
  assign right_psum_o = right_psum_q;

endmodule

`default_nettype wire

FILE: rtl/dsdf_power_acc.sv
// ----------------------------------------------------------------------------
// dsdf_power_acc
// Window energy of one steering: registers the steered sum, squares it and
// adds it into a saturating accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module dsdf_power_acc (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  dsdf_pkg::acc_ctrl_t                   ctrl_i,
  input  wire  signed [dsdf_pkg::SumW-1:0]      sum_i,
  output logic        [dsdf_pkg::PowerW-1:0]    power_o
);

  logic signed [dsdf_pkg::SumW-1:0]   sum_q;
  logic        [dsdf_pkg::SumW-1:0]   mag;
  logic        [dsdf_pkg::SqW-1:0]    sq_q;
  logic        [dsdf_pkg::PowerW:0]   total;
  logic        [dsdf_pkg::PowerW-1:0] acc_q, acc_d;

  // the most negative sum maps to 2^20, still fits unsigned
  assign mag   = sum_q[dsdf_pkg::SumW-1] ? -sum_q : sum_q;
  assign total = {1'b0, acc_q} + (dsdf_pkg::PowerW + 1)'(sq_q);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en) begin
      acc_d = (total > (dsdf_pkg::PowerW + 1)'(dsdf_pkg::PowerMax)) ?
              dsdf_pkg::PowerMax : total[dsdf_pkg::PowerW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      sum_q <= sum_i;
    end
    if (ctrl_i.sq_en) begin
      sq_q <= dsdf_pkg::SqW'(mag) * dsdf_pkg::SqW'(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign power_o = acc_q;

endmodule

`default_nettype wire

FILE: rtl/dsdf_vote.sv
// ----------------------------------------------------------------------------
// dsdf_vote
// Picks the loudest steering of a window, keeps the vote counters and the
// window counter, and gives the smoothed position at each decision.
// ----------------------------------------------------------------------------
`default_nettype none

module dsdf_vote #(
  parameter int WINDOWS_PER_DECISION = dsdf_pkg::WinPerDecisionDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                win_end_i,
  input  wire  [dsdf_pkg::PowerW-1:0]        center_power_i,
  input  wire  [dsdf_pkg::PowerW-1:0]        left_power_i,
  input  wire  [dsdf_pkg::PowerW-1:0]        right_power_i,
  output logic [dsdf_pkg::DirW-1:0]          dir_o,
  output logic                               pos_valid_o,
  output logic [dsdf_pkg::DirW-1:0]          pos_o
);

  localparam int WinW = (WINDOWS_PER_DECISION > 1) ? $clog2(WINDOWS_PER_DECISION) : 1;

  // strict compares: a tie with right goes right, a center-left tie goes left
  function automatic logic [dsdf_pkg::DirW-1:0] pick(
    input logic [dsdf_pkg::PowerW-1:0] c,
    input logic [dsdf_pkg::PowerW-1:0] l,
    input logic [dsdf_pkg::PowerW-1:0] r
  );
    logic [dsdf_pkg::DirW-1:0] d;
    if (c > l) begin
      d = (c > r) ? dsdf_pkg::DirCenter : dsdf_pkg::DirRight;
    end else begin
      d = (l > r) ? dsdf_pkg::DirLeft : dsdf_pkg::DirRight;
    end
    return d;
  endfunction

  logic [dsdf_pkg::VoteW-1:0] cv_q, lv_q, rv_q;
  logic [dsdf_pkg::VoteW-1:0] cv_n, lv_n, rv_n;
  logic [WinW-1:0]            win_q;
  logic                       last;

  assign dir_o = pick(center_power_i, left_power_i, right_power_i);
  assign last  = (win_q == WinW'(WINDOWS_PER_DECISION - 1));

  always_comb begin
    cv_n = cv_q;
    lv_n = lv_q;
    rv_n = rv_q;
    unique case (dir_o)
      dsdf_pkg::DirCenter: if (cv_q != dsdf_pkg::VoteMax) cv_n = cv_q + 1'b1;
      dsdf_pkg::DirLeft:   if (lv_q != dsdf_pkg::VoteMax) lv_n = lv_q + 1'b1;
      default:             if (rv_q != dsdf_pkg::VoteMax) rv_n = rv_q + 1'b1;
    endcase
  end

  assign pos_valid_o = last;
  assign pos_o = last ? pick(dsdf_pkg::PowerW'(cv_n), dsdf_pkg::PowerW'(lv_n),
                             dsdf_pkg::PowerW'(rv_n))
                      : dsdf_pkg::DirCenter;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q  <= '0;
      lv_q  <= '0;
      rv_q  <= '0;
      win_q <= '0;
    end else if (win_end_i) begin
      if (last) begin
        cv_q  <= cv_n >> 2;
        lv_q  <= lv_n >> 2;
        rv_q  <= rv_n >> 2;
        win_q <= '0;
      end else begin
        cv_q  <= cv_n;
        lv_q  <= lv_n;
        rv_q  <= rv_n;
        win_q <= win_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/stereo_delay_sum_direction_finder.sv
// ----------------------------------------------------------------------------
// stereo_delay_sum_direction_finder
// Two-microphone delay-and-sum direction finder: FIR per channel, energy of
// three steerings per window, loudest direction and a smoothed position.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  cfg      | cfg_we_i                   | cfg_index_i, cfg_data_i
//  in       | in_valid_i / in_stall_o    | left_sample_i, right_sample_i
//  out      | out_valid_o / out_stall_i  | powers, window_direction, position
//
//  A sample pair is accepted in StIdle and then passes StFir, StSum, StSq and
//  StAcc; the partial sums ripple one tap cell per cycle down the chain. A
//  window end adds StPick to load the output register, and StPick waits while a
//  previous result is still stalled there. in_stall_o is high while a pair is in
//  work. Reset clears histories, delay lines, energies, votes and coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_delay_sum_direction_finder #(
  parameter int TAP_COUNT            = dsdf_pkg::TapCountDef,
  parameter int WINDOW_SAMPLES       = dsdf_pkg::WindowSamplesDef,
  parameter int STEER_LAG            = dsdf_pkg::SteerLagDef,
  parameter int WINDOWS_PER_DECISION = dsdf_pkg::WinPerDecisionDef
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [dsdf_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  wire  [dsdf_pkg::CoefW-1:0]            cfg_data_i,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  signed [dsdf_pkg::SampleW-1:0]   left_sample_i,
  input  wire  signed [dsdf_pkg::SampleW-1:0]   right_sample_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [dsdf_pkg::PowerW-1:0]           center_power_o,
  output logic [dsdf_pkg::PowerW-1:0]           left_power_o,
  output logic [dsdf_pkg::PowerW-1:0]           right_power_o,
  output logic [dsdf_pkg::DirW-1:0]             window_direction_o,
  output logic                                  position_valid_o,
  output logic [dsdf_pkg::DirW-1:0]             position_o
);

  localparam int CntW  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int SmpW  = $clog2(WINDOW_SAMPLES);

  typedef enum logic [2:0] {
    StIdle,
    StFir,
    StSum,
    StSq,
    StAcc,
    StPick
  } state_e;

  state_e                     state_q;
  logic [CntW-1:0]            fir_cnt_q;
  logic [SmpW-1:0]            smp_cnt_q;
  logic                       accept;
  logic                       out_free;
  logic                       win_end;

  // configuration
  logic signed [dsdf_pkg::CoefW-1:0] coef_q [dsdf_pkg::CoefRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dsdf_pkg::CoefRegs; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // tap cell chain, cell 0 holds the newest sample
  logic signed [dsdf_pkg::SampleW-1:0] lsmp [TAP_COUNT+1];
  logic signed [dsdf_pkg::SampleW-1:0] rsmp [TAP_COUNT+1];
  logic signed [dsdf_pkg::PsumW-1:0]   lpsum [TAP_COUNT+1];
  logic signed [dsdf_pkg::PsumW-1:0]   rpsum [TAP_COUNT+1];

  assign lsmp[0]  = left_sample_i;
  assign rsmp[0]  = right_sample_i;
  assign lpsum[0] = '0;
  assign rpsum[0] = '0;

  for (genvar j = 0; j < TAP_COUNT; j++) begin : g_tap
    dsdf_tap_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (accept),
      .coef_i       (coef_q[TAP_COUNT-1-j]),
      .left_i       (lsmp[j]),
      .right_i      (rsmp[j]),
      .left_psum_i  (lpsum[j]),
      .right_psum_i (rpsum[j]),
      .left_o       (lsmp[j+1]),
      .right_o      (rsmp[j+1]),
      .left_psum_o  (lpsum[j+1]),
      .right_psum_o (rpsum[j+1])
    );
  end

  // floor shift by 16 is a plain bit select
  logic signed [dsdf_pkg::FiltW-1:0] fl, fr;
  assign fl = lpsum[TAP_COUNT][dsdf_pkg::PsumW-1:dsdf_pkg::FracBits];
  assign fr = rpsum[TAP_COUNT][dsdf_pkg::PsumW-1:dsdf_pkg::FracBits];

  // steering delay lines
  logic signed [dsdf_pkg::FiltW-1:0] ldly_q [STEER_LAG];
  logic signed [dsdf_pkg::FiltW-1:0] rdly_q [STEER_LAG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STEER_LAG; i++) begin
        ldly_q[i] <= '0;
        rdly_q[i] <= '0;
      end
    end else if (state_q == StSum) begin
      ldly_q[0] <= fl;
      rdly_q[0] <= fr;
      for (int i = 1; i < STEER_LAG; i++) begin
        ldly_q[i] <= ldly_q[i-1];
        rdly_q[i] <= rdly_q[i-1];
      end
    end
  end

  logic signed [dsdf_pkg::SumW-1:0] c_sum, l_sum, r_sum;
  assign c_sum = dsdf_pkg::SumW'(fl) + dsdf_pkg::SumW'(fr);
  assign l_sum = dsdf_pkg::SumW'(ldly_q[STEER_LAG-1]) + dsdf_pkg::SumW'(fr);
  assign r_sum = dsdf_pkg::SumW'(fl) + dsdf_pkg::SumW'(rdly_q[STEER_LAG-1]);

  dsdf_pkg::acc_ctrl_t acc_ctrl;
  assign acc_ctrl.sum_en = (state_q == StSum);
  assign acc_ctrl.sq_en  = (state_q == StSq);
  assign acc_ctrl.acc_en = (state_q == StAcc);
  assign acc_ctrl.clr    = win_end;

  logic [dsdf_pkg::PowerW-1:0] c_pow, l_pow, r_pow;

  dsdf_power_acc u_center (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (acc_ctrl), .sum_i (c_sum), .power_o (c_pow)
  );
  dsdf_power_acc u_left (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (acc_ctrl), .sum_i (l_sum), .power_o (l_pow)
  );
  dsdf_power_acc u_right (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (acc_ctrl), .sum_i (r_sum), .power_o (r_pow)
  );

  logic [dsdf_pkg::DirW-1:0] dir, pos;
  logic                      pos_valid;

  dsdf_vote #(
    .WINDOWS_PER_DECISION (WINDOWS_PER_DECISION)
  ) u_vote (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .win_end_i      (win_end),
    .center_power_i (c_pow),
    .left_power_i   (l_pow),
    .right_power_i  (r_pow),
    .dir_o          (dir),
    .pos_valid_o    (pos_valid),
    .pos_o          (pos)
  );

  assign accept     = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);
  assign out_free   = !out_valid_o || !out_stall_i;
  assign win_end    = (state_q == StPick) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= StIdle;
      fir_cnt_q          <= '0;
      smp_cnt_q          <= '0;
      out_valid_o        <= 1'b0;
      center_power_o     <= '0;
      left_power_o       <= '0;
      right_power_o      <= '0;
      window_direction_o <= dsdf_pkg::DirCenter;
      position_valid_o   <= 1'b0;
      position_o         <= dsdf_pkg::DirCenter;
    end else begin
      if (win_end) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            fir_cnt_q <= '0;
            state_q   <= StFir;
          end
        end
        StFir: begin
          fir_cnt_q <= fir_cnt_q + 1'b1;
          if (fir_cnt_q == CntW'(TAP_COUNT - 1)) begin
            state_q <= StSum;
          end
        end
        StSum: state_q <= StSq;
        StSq:  state_q <= StAcc;
        StAcc: begin
          if (smp_cnt_q == SmpW'(WINDOW_SAMPLES - 1)) begin
            smp_cnt_q <= '0;
            state_q   <= StPick;
          end else begin
            smp_cnt_q <= smp_cnt_q + 1'b1;
            state_q   <= StIdle;
          end
        end
        StPick: begin
          if (out_free) begin
            center_power_o     <= c_pow;
            left_power_o       <= l_pow;
            right_power_o      <= r_pow;
            window_direction_o <= dir;
            position_valid_o   <= pos_valid;
            position_o         <= pos;
            state_q            <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire
